[rtl/lruk_pkg.sv]
// shared constants, codes and control structs for the lru-k frame replacer
// no dependencies; used by every module of the block by scoped names
package lruk_pkg;

   localparam int FRAME_COUNT_DEF = 64;
   localparam int MAX_K_DEF       = 8;
   localparam int STAMP_BITS_DEF  = 32;

   localparam int KIND_W      = 2;
   localparam int FRAME_W     = 8;
   localparam int STATUS_W    = 2;
   localparam int VICTIM_W    = 6;
   localparam int COUNT_W     = 7;
   localparam int K_W         = 4;
   localparam int LIMIT_W     = 7;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;

   localparam logic [K_W-1:0]     K_RESET     = 4'd2;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic [KIND_W-1:0] KIND_ACCESS    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET_EVICT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EVICT     = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_DONE          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_EVICTABLE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_VICTIM     = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_K_VALUE       = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAMES_IN_USE = 1'd1;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } hist_ctl_type;

   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

   // ring slot index bits per frame: slots are the next power of two at or above max_k, at least two
   function automatic int slot_bits(input int max_k);
      int bits;
      bits = (max_k > 1) ? $clog2(max_k) : 1;
      return bits;
   endfunction

endpackage

[rtl/lru_k_frame_replacer.sv]
// lru-k frame replacer top level: sequencer, frame record memory and config registers
// depends on lruk_pkg, lruk_history and lruk_victim_sel
//
// usage
//   one request per transaction: drive req_kind, req_frame and req_evictable_flag with
//   start; the transaction is taken at a rising edge with start high and busy low.
//   every request returns exactly one response, shown on rsp_* for one cycle while
//   rsp_valid is high. the receiver has no way to hold it off and must take it then.
//   csr_we with csr_index and csr_wdata writes k_value (index 0) or frames_in_use
//   (index 1) at the edge; write only while busy is low.
// operation
//   access, set evictable and remove: read-modify-write of the frame record through
//   the read and update states; the registered response appears as busy drops.
//   evict: one frame record read per cycle over all FRAME_COUNT frames, the stamp read
//   and compare follow behind in the scan stages; once they have drained, the winner's
//   record is cleared as the response appears.
// reset
//   synchronous reset clears the config to k_value 2, frames_in_use 64, the stamp
//   counter and evictable count to zero, then a clearing pass writes every frame
//   record, one per cycle; busy stays high meanwhile.
module lru_k_frame_replacer #(
   parameter int FRAME_COUNT = lruk_pkg::FRAME_COUNT_DEF,
   parameter int MAX_K       = lruk_pkg::MAX_K_DEF,
   parameter int STAMP_BITS  = lruk_pkg::STAMP_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lruk_pkg::KIND_W-1:0]         req_kind,
   input  logic [lruk_pkg::FRAME_W-1:0]        req_frame,
   input  logic                                req_evictable_flag,
   output logic                                rsp_valid,
   output logic [lruk_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lruk_pkg::VICTIM_W-1:0]       rsp_victim_frame,
   output logic [lruk_pkg::COUNT_W-1:0]        rsp_evictable_count,
   input  logic                                csr_we,
   input  logic [lruk_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lruk_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FRAME_BITS = $clog2(FRAME_COUNT);
   localparam int SLOT_BITS  = lruk_pkg::slot_bits(MAX_K);
   localparam int CNT_BITS   = $clog2(MAX_K + 1);
   localparam int TOTAL_BITS = $clog2(FRAME_COUNT + 1);
   localparam int META_W     = 2 + CNT_BITS + SLOT_BITS;
   localparam logic [FRAME_BITS-1:0] LAST_FRAME = FRAME_BITS'(FRAME_COUNT - 1);
   localparam logic [CNT_BITS-1:0]   MAX_K_CNT  = CNT_BITS'(MAX_K);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type                       state_ff, state_in;
   logic [FRAME_BITS-1:0]           idx_ff, idx_in;
   logic [lruk_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [lruk_pkg::FRAME_W-1:0]    frame_ff, frame_in;
   logic                            flag_ff, flag_in;
   logic                            in_range_ff, in_range_in;
   logic [STAMP_BITS-1:0]           stamp_ff, stamp_in;
   logic [TOTAL_BITS-1:0]           total_ff, total_in;
   logic [lruk_pkg::K_W-1:0]        k_ff, k_in;
   logic [lruk_pkg::LIMIT_W-1:0]    limit_ff, limit_in;
   logic                            s1_valid_ff, s1_valid_in;
   logic [FRAME_BITS-1:0]           s1_frame_ff, s1_frame_in;
   logic                            s2_valid_ff, s2_valid_in;
   logic                            s2_inf_ff, s2_inf_in;
   logic [FRAME_BITS-1:0]           s2_frame_ff, s2_frame_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lruk_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [lruk_pkg::VICTIM_W-1:0]   rsp_victim_ff, rsp_victim_in;
   logic [lruk_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [META_W-1:0]               meta_mem [FRAME_COUNT];
   logic [META_W-1:0]               meta_rd_ff;
   logic                            meta_we;
   logic [FRAME_BITS-1:0]           meta_waddr;
   logic [META_W-1:0]               meta_wdata;
   logic [FRAME_BITS-1:0]           meta_raddr;

   logic                            m_tracked;
   logic                            m_evict;
   logic [CNT_BITS-1:0]             m_count;
   logic [SLOT_BITS-1:0]            m_head;
   logic [SLOT_BITS-1:0]            next_head;
   logic [CNT_BITS:0]               count_inc;
   logic [CNT_BITS-1:0]             count_acc;
   logic [CNT_BITS-1:0]             eff_k;
   logic [FRAME_BITS-1:0]           frame_idx;
   logic                            s1_cand;
   logic                            s1_inf;
   logic [CNT_BITS-1:0]             s1_index;

   lruk_pkg::hist_ctl_type          hist_ctl;
   lruk_pkg::scan_ctl_type          scan_ctl;
   logic [STAMP_BITS-1:0]           hist_rd_stamp;
   logic                            vic_found;
   logic [FRAME_BITS-1:0]           vic_frame;

   assign frame_idx = FRAME_BITS'(frame_ff);
   assign {m_tracked, m_evict, m_count, m_head} = meta_rd_ff;
   assign next_head = m_head + SLOT_BITS'(1);
   assign meta_raddr = (state_ff == ST_SCAN) ? idx_ff : frame_idx;

   // k of zero behaves as one, above MAX_K as MAX_K
   always_comb begin
      if (k_ff == '0) begin
         eff_k = CNT_BITS'(1);
      end else if (32'(k_ff) > MAX_K) begin
         eff_k = MAX_K_CNT;
      end else begin
         eff_k = CNT_BITS'(k_ff);
      end
   end

   always_comb begin
      count_inc = {1'b0, m_count} + (CNT_BITS + 1)'(1);
      if (count_inc > {1'b0, eff_k}) begin
         count_acc = eff_k;
      end else begin
         count_acc = CNT_BITS'(count_inc);
      end
   end

   // scan stage one: judge the record read last cycle, pick which stamp to fetch
   always_comb begin
      s1_cand  = m_tracked && m_evict && (m_count != '0);
      s1_inf   = m_count < eff_k;
      s1_index = s1_inf ? (m_count - CNT_BITS'(1)) : (eff_k - CNT_BITS'(1));
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      frame_in      = frame_ff;
      flag_in       = flag_ff;
      in_range_in   = in_range_ff;
      stamp_in      = stamp_ff;
      total_in      = total_ff;
      k_in          = k_ff;
      limit_in      = limit_ff;
      s1_valid_in   = 1'b0;
      s1_frame_in   = idx_ff;
      s2_valid_in   = s1_valid_ff && s1_cand;
      s2_inf_in     = s1_inf;
      s2_frame_in   = s1_frame_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_count_in  = rsp_count_ff;
      meta_we       = 1'b0;
      meta_waddr    = frame_idx;
      meta_wdata    = '0;
      hist_ctl.rd_en = s1_valid_ff;
      hist_ctl.wr_en = 1'b0;
      scan_ctl.clear  = 1'b0;
      scan_ctl.sample = s2_valid_ff;

      if (csr_we) begin
         case (csr_index)
            lruk_pkg::CSR_K_VALUE:       k_in = csr_wdata[lruk_pkg::K_W-1:0];
            lruk_pkg::CSR_FRAMES_IN_USE: limit_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = idx_ff;
            idx_in     = idx_ff + FRAME_BITS'(1);
            if (idx_ff == LAST_FRAME) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               kind_in     = req_kind;
               frame_in    = req_frame;
               flag_in     = req_evictable_flag;
               in_range_in = (32'(req_frame) < 32'(FRAME_COUNT)) &&
                             (32'(req_frame) < 32'(limit_ff));
               if (req_kind == lruk_pkg::KIND_EVICT) begin
                  idx_in         = '0;
                  scan_ctl.clear = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            rsp_status_in = lruk_pkg::STATUS_IGNORED;
            rsp_victim_in = '0;
            if (in_range_ff) begin
               case (kind_ff)
                  lruk_pkg::KIND_ACCESS: begin
                     rsp_status_in  = lruk_pkg::STATUS_DONE;
                     meta_we        = 1'b1;
                     hist_ctl.wr_en = 1'b1;
                     if (m_tracked) begin
                        meta_wdata = {1'b1, m_evict, count_acc, next_head};
                     end else begin
                        meta_wdata = {1'b1, 1'b0, CNT_BITS'(1), next_head};
                     end
                     if (stamp_ff != '1) begin
                        stamp_in = stamp_ff + STAMP_BITS'(1);
                     end
                  end
                  lruk_pkg::KIND_SET_EVICT: begin
                     if (m_tracked) begin
                        rsp_status_in = lruk_pkg::STATUS_DONE;
                        meta_we       = 1'b1;
                        meta_wdata    = {1'b1, flag_ff, m_count, m_head};
                        if (flag_ff && !m_evict) begin
                           total_in = total_ff + TOTAL_BITS'(1);
                        end else if (!flag_ff && m_evict && (total_ff != '0)) begin
                           total_in = total_ff - TOTAL_BITS'(1);
                        end
                     end
                  end
                  lruk_pkg::KIND_REMOVE: begin
                     if (m_tracked) begin
                        if (!m_evict) begin
                           rsp_status_in = lruk_pkg::STATUS_NOT_EVICTABLE;
                        end else begin
                           rsp_status_in = lruk_pkg::STATUS_DONE;
                           meta_we       = 1'b1;
                           if (total_ff != '0) begin
                              total_in = total_ff - TOTAL_BITS'(1);
                           end
                        end
                     end
                  end
                  default: ;
               endcase
            end
            rsp_valid_in = 1'b1;
            rsp_count_in = lruk_pkg::COUNT_W'(total_in);
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            s1_valid_in = 1'b1;
            s1_frame_in = idx_ff;
            idx_in      = idx_ff + FRAME_BITS'(1);
            if (idx_ff == LAST_FRAME) begin
               idx_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last two scan stages to empty into the selector
            if (!s1_valid_ff && !s2_valid_ff) begin
               if (vic_found) begin
                  meta_we       = 1'b1;
                  meta_waddr    = vic_frame;
                  rsp_status_in = lruk_pkg::STATUS_DONE;
                  rsp_victim_in = lruk_pkg::VICTIM_W'(vic_frame);
                  if (total_ff != '0) begin
                     total_in = total_ff - TOTAL_BITS'(1);
                  end
               end else begin
                  rsp_status_in = lruk_pkg::STATUS_NO_VICTIM;
                  rsp_victim_in = '0;
               end
               rsp_valid_in = 1'b1;
               rsp_count_in = lruk_pkg::COUNT_W'(total_in);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         stamp_ff     <= '0;
         total_ff     <= '0;
         k_ff         <= lruk_pkg::K_RESET;
         limit_ff     <= lruk_pkg::LIMIT_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         stamp_ff     <= stamp_in;
         total_ff     <= total_in;
         k_ff         <= k_in;
         limit_ff     <= limit_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      frame_ff      <= frame_in;
      flag_ff       <= flag_in;
      in_range_ff   <= in_range_in;
      s1_frame_ff   <= s1_frame_in;
      s2_inf_ff     <= s2_inf_in;
      s2_frame_ff   <= s2_frame_in;
      rsp_status_ff <= rsp_status_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_count_ff  <= rsp_count_in;
   end

   lruk_history #(
      .FRAME_COUNT (FRAME_COUNT),
      .MAX_K       (MAX_K),
      .STAMP_BITS  (STAMP_BITS)
   ) u_history (
      .clock    (clock),
      .ctl      (hist_ctl),
      .wr_frame (frame_idx),
      .wr_slot  (next_head),
      .wr_stamp (stamp_ff),
      .rd_frame (s1_frame_ff),
      .rd_head  (m_head),
      .rd_index (s1_index),
      .rd_stamp (hist_rd_stamp)
   );

   lruk_victim_sel #(
      .FRAME_COUNT (FRAME_COUNT),
      .STAMP_BITS  (STAMP_BITS)
   ) u_victim_sel (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .cand_inf   (s2_inf_ff),
      .cand_stamp (hist_rd_stamp),
      .cand_frame (s2_frame_ff),
      .found      (vic_found),
      .best_frame (vic_frame)
   );

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_victim_frame    = rsp_victim_ff;
   assign rsp_evictable_count = rsp_count_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("transaction taken without entering a busy phase");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("scan pipeline not empty while idle");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= 32'(FRAME_COUNT))
      else $error("evictable count above frame count");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != lruk_pkg::STATUS_DONE)) |-> (rsp_victim_frame == '0))
      else $error("victim frame reported on a failed transaction");

endmodule

[rtl/lruk_history.sv]
// per-frame stamp history kept as a ring in one synchronous memory
// depends on lruk_pkg for the slot width and the control struct
module lruk_history #(
   parameter int FRAME_COUNT = lruk_pkg::FRAME_COUNT_DEF,
   parameter int MAX_K       = lruk_pkg::MAX_K_DEF,
   parameter int STAMP_BITS  = lruk_pkg::STAMP_BITS_DEF
) (
   input  logic                                   clock,
   input  lruk_pkg::hist_ctl_type                 ctl,
   input  logic [$clog2(FRAME_COUNT)-1:0]         wr_frame,
   input  logic [lruk_pkg::slot_bits(MAX_K)-1:0]  wr_slot,
   input  logic [STAMP_BITS-1:0]                  wr_stamp,
   input  logic [$clog2(FRAME_COUNT)-1:0]         rd_frame,
   input  logic [lruk_pkg::slot_bits(MAX_K)-1:0]  rd_head,
   input  logic [$clog2(MAX_K+1)-1:0]             rd_index,
   output logic [STAMP_BITS-1:0]                  rd_stamp
);

   localparam int FRAME_BITS = $clog2(FRAME_COUNT);
   localparam int SLOT_BITS  = lruk_pkg::slot_bits(MAX_K);
   localparam int DEPTH      = FRAME_COUNT * (2 ** SLOT_BITS);

   logic [STAMP_BITS-1:0]           stamp_mem [DEPTH];
   logic [STAMP_BITS-1:0]           rd_stamp_ff;
   logic [SLOT_BITS-1:0]            rd_slot;
   logic [FRAME_BITS+SLOT_BITS-1:0] rd_addr;
   logic [FRAME_BITS+SLOT_BITS-1:0] wr_addr;

   // i-th newest stamp sits i slots behind the head, modulo the ring size
   assign rd_slot = rd_head - SLOT_BITS'(rd_index);
   assign rd_addr = {rd_frame, rd_slot};
   assign wr_addr = {wr_frame, wr_slot};

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
      if (ctl.rd_en) begin
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
   end

   assign rd_stamp = rd_stamp_ff;

endmodule

[rtl/lruk_victim_sel.sv]
// running best-candidate register for the eviction scan
// depends on lruk_pkg for the scan control struct
module lruk_victim_sel #(
   parameter int FRAME_COUNT = lruk_pkg::FRAME_COUNT_DEF,
   parameter int STAMP_BITS  = lruk_pkg::STAMP_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lruk_pkg::scan_ctl_type         ctl,
   input  logic                           cand_inf,
   input  logic [STAMP_BITS-1:0]          cand_stamp,
   input  logic [$clog2(FRAME_COUNT)-1:0] cand_frame,
   output logic                           found,
   output logic [$clog2(FRAME_COUNT)-1:0] best_frame
);

   localparam int FRAME_BITS = $clog2(FRAME_COUNT);

   logic                  found_ff;
   logic                  found_in;
   logic                  best_inf_ff;
   logic                  best_inf_in;
   logic [STAMP_BITS-1:0] best_stamp_ff;
   logic [STAMP_BITS-1:0] best_stamp_in;
   logic [FRAME_BITS-1:0] best_frame_ff;
   logic [FRAME_BITS-1:0] best_frame_in;
   logic                  better;

   // infinite distance beats finite; within a class the older stamp wins,
   // ties keep the earlier (lower) frame
   always_comb begin
      better = !found_ff || (cand_inf && !best_inf_ff) ||
               ((cand_inf == best_inf_ff) && (cand_stamp < best_stamp_ff));
      found_in      = found_ff;
      best_inf_in   = best_inf_ff;
      best_stamp_in = best_stamp_ff;
      best_frame_in = best_frame_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample && better) begin
         found_in      = 1'b1;
         best_inf_in   = cand_inf;
         best_stamp_in = cand_stamp;
         best_frame_in = cand_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_inf_ff   <= best_inf_in;
      best_stamp_ff <= best_stamp_in;
      best_frame_ff <= best_frame_in;
   end

   assign found      = found_ff;
   assign best_frame = best_frame_ff;

endmodule

[bench/lru_k_frame_replacer_tb.sv]
// self-checking testbench for lru_k_frame_replacer: directed and random requests
// against an in-bench lru-k predictor, with random start gaps and config phases
// depends on lruk_pkg and the lru_k_frame_replacer rtl
module lru_k_frame_replacer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [lruk_pkg::KIND_W-1:0]  kind;
      logic [lruk_pkg::FRAME_W-1:0] frame;
      logic                         flag;
   } replacer_req_type;

   typedef struct packed {
      logic [lruk_pkg::STATUS_W-1:0] status;
      logic [lruk_pkg::VICTIM_W-1:0] victim;
      logic [lruk_pkg::COUNT_W-1:0]  count;
   } replacer_rsp_type;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [lruk_pkg::KIND_W-1:0]      req_kind = lruk_pkg::KIND_ACCESS;
   logic [lruk_pkg::FRAME_W-1:0]     req_frame = '0;
   logic                             req_evictable_flag = 1'b0;
   logic                             rsp_valid;
   logic [lruk_pkg::STATUS_W-1:0]    rsp_status;
   logic [lruk_pkg::VICTIM_W-1:0]    rsp_victim_frame;
   logic [lruk_pkg::COUNT_W-1:0]     rsp_evictable_count;
   logic                             csr_we = 1'b0;
   logic [lruk_pkg::CSR_INDEX_W-1:0] csr_index = lruk_pkg::CSR_K_VALUE;
   logic [lruk_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor state
   logic [lruk_pkg::K_W-1:0]     k_cfg;
   logic [lruk_pkg::LIMIT_W-1:0] limit_cfg;
   logic               tracked    [lruk_pkg::FRAME_COUNT_DEF];
   logic               evict_mark [lruk_pkg::FRAME_COUNT_DEF];
   logic [3:0]         hist_cnt   [lruk_pkg::FRAME_COUNT_DEF];
   logic [lruk_pkg::STAMP_BITS_DEF-1:0]
      stamps [lruk_pkg::FRAME_COUNT_DEF][lruk_pkg::MAX_K_DEF];
   logic [lruk_pkg::STAMP_BITS_DEF-1:0] stamp_ctr;
   logic [lruk_pkg::COUNT_W-1:0] evict_total;

   replacer_req_type pending_q[$];
   replacer_rsp_type expected_rsp_q[$];
   replacer_req_type cur_req;
   int               accepted_count = 0;
   int               mismatches = 0;

   lru_k_frame_replacer dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_frame(req_frame),
      .req_evictable_flag(req_evictable_flag),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_victim_frame(rsp_victim_frame),
      .rsp_evictable_count(rsp_evictable_count),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("lru_k_frame_replacer test failed");
      $finish;
   end

   function automatic void drop_frame(input int unsigned f);
      tracked[f] = 1'b0;
      evict_mark[f] = 1'b0;
      hist_cnt[f] = '0;
   endfunction

   // applies one request to the predictor state and returns its response
   function automatic replacer_rsp_type replacer_step(input replacer_req_type r);
      int unsigned kk, lim, c, f, best, i;
      logic found, best_inf, inf_dist;
      logic [lruk_pkg::STAMP_BITS_DEF-1:0] s, best_stamp;
      replacer_rsp_type o;
      kk = (k_cfg == 0) ? 1 :
           (32'(k_cfg) > lruk_pkg::MAX_K_DEF) ? lruk_pkg::MAX_K_DEF : 32'(k_cfg);
      lim = (32'(limit_cfg) > lruk_pkg::FRAME_COUNT_DEF) ?
            lruk_pkg::FRAME_COUNT_DEF : 32'(limit_cfg);
      o.status = lruk_pkg::STATUS_IGNORED;
      o.victim = '0;
      if (r.kind == lruk_pkg::KIND_EVICT) begin
         found = 1'b0;
         best_inf = 1'b0;
         best_stamp = '0;
         best = 0;
         for (f = 0; f < lruk_pkg::FRAME_COUNT_DEF; f++) begin
            c = 32'(hist_cnt[f]);
            if (tracked[f] && evict_mark[f] && c != 0) begin
               if (c > lruk_pkg::MAX_K_DEF) c = lruk_pkg::MAX_K_DEF;
               // fewer than k stamps means infinite backward distance
               inf_dist = (c < kk);
               s = inf_dist ? stamps[f][c-1] : stamps[f][kk-1];
               if (!found || (inf_dist && !best_inf) ||
                   (inf_dist == best_inf && s < best_stamp)) begin
                  found = 1'b1;
                  best_inf = inf_dist;
                  best_stamp = s;
                  best = f;
               end
            end
         end
         if (found) begin
            drop_frame(best);
            if (evict_total > 0) evict_total--;
            o.status = lruk_pkg::STATUS_DONE;
            o.victim = best[lruk_pkg::VICTIM_W-1:0];
         end else begin
            o.status = lruk_pkg::STATUS_NO_VICTIM;
         end
      end else if (32'(r.frame) < lim) begin
         f = 32'(r.frame);
         if (r.kind == lruk_pkg::KIND_ACCESS) begin
            s = stamp_ctr;
            if (stamp_ctr != '1) stamp_ctr++;
            if (!tracked[f]) begin
               tracked[f] = 1'b1;
               evict_mark[f] = 1'b0;
               stamps[f][0] = s;
               hist_cnt[f] = 4'd1;
            end else begin
               c = 32'(hist_cnt[f]) + 1;
               if (c > kk) c = kk;
               for (i = lruk_pkg::MAX_K_DEF - 1; i > 0; i--) stamps[f][i] = stamps[f][i-1];
               stamps[f][0] = s;
               hist_cnt[f] = 4'(c);
            end
            o.status = lruk_pkg::STATUS_DONE;
         end else if (tracked[f]) begin
            if (r.kind == lruk_pkg::KIND_SET_EVICT) begin
               if (r.flag && !evict_mark[f]) evict_total++;
               else if (!r.flag && evict_mark[f] && evict_total > 0) evict_total--;
               evict_mark[f] = r.flag;
               o.status = lruk_pkg::STATUS_DONE;
            end else if (!evict_mark[f]) begin
               o.status = lruk_pkg::STATUS_NOT_EVICTABLE;
            end else begin
               drop_frame(f);
               if (evict_total > 0) evict_total--;
               o.status = lruk_pkg::STATUS_DONE;
            end
         end
      end
      o.count = evict_total;
      return o;
   endfunction

   // request driver: start is held until busy is low at an edge
   always @(posedge clock) begin : driver
      logic go;
      replacer_rsp_type next_rsp;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            next_rsp = replacer_step(cur_req);
            expected_rsp_q = {expected_rsp_q, next_rsp};
            accepted_count++;
         end
         if (!start || !busy) begin
            go = pending_q.size() != 0 &&
                 ((accepted_count >= 400 && accepted_count < 700) ||
                  $urandom_range(99) >= 31);
            if (go) begin
               cur_req = pending_q.pop_front();
               req_kind <= cur_req.kind;
               req_frame <= cur_req.frame;
               req_evictable_flag <= cur_req.flag;
            end
            start <= go;
         end
      end
   end

   always @(posedge clock) begin : monitor
      replacer_rsp_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_status, rsp_victim_frame, rsp_evictable_count};
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected transaction, expected none, got status %0d victim %0d count %0d",
                     $time, got.status, got.victim, got.count);
         end else begin
            want = expected_rsp_q.pop_front();
            if (got !== want) begin
               mismatches++;
               $display("%0t: expected status %0d victim %0d count %0d, %s %0d victim %0d count %0d",
                        $time, want.status, want.victim, want.count, "got status",
                        got.status, got.victim, got.count);
            end
         end
      end
   end

   function automatic void push_req(input logic [lruk_pkg::KIND_W-1:0] kind,
                                    input logic [lruk_pkg::FRAME_W-1:0] frame,
                                    input logic flag);
      replacer_req_type item;
      item = '{kind, frame, flag};
      pending_q = {pending_q, item};
   endfunction

   function automatic logic [lruk_pkg::FRAME_W-1:0] pick_frame(input int unsigned lim, hot);
      int unsigned r;
      r = $urandom_range(99);
      if (lim == 0 || r < 6) return lruk_pkg::FRAME_W'($urandom_range(255));
      if (r < 70) return lruk_pkg::FRAME_W'($urandom_range(hot - 1));
      return lruk_pkg::FRAME_W'($urandom_range(lim - 1));
   endfunction

   task automatic add_random(input int n, input logic fill);
      int unsigned lim, hot, r, reps, i;
      logic [lruk_pkg::FRAME_W-1:0] f;
      lim = (32'(limit_cfg) > lruk_pkg::FRAME_COUNT_DEF) ?
            lruk_pkg::FRAME_COUNT_DEF : 32'(limit_cfg);
      hot = (lim < 10) ? lim : 10;
      // track every frame below the limit and mark it evictable so the count reaches its top
      if (fill) begin
         for (i = 0; i < lim; i++) begin
            push_req(lruk_pkg::KIND_ACCESS, lruk_pkg::FRAME_W'(i), 1'b0);
            push_req(lruk_pkg::KIND_SET_EVICT, lruk_pkg::FRAME_W'(i), 1'b1);
         end
      end
      i = 0;
      while (i < n) begin
         f = pick_frame(lim, hot);
         r = $urandom_range(99);
         if (r < 12) begin
            // burst of accesses then release, so k-distances become finite
            reps = $urandom_range(9, 1);
            repeat (reps) push_req(lruk_pkg::KIND_ACCESS, f, 1'($urandom_range(1)));
            push_req(lruk_pkg::KIND_SET_EVICT, f, 1'b1);
            i += reps + 1;
         end else begin
            if (r < 45) push_req(lruk_pkg::KIND_ACCESS, f, 1'($urandom_range(1)));
            else if (r < 68) push_req(lruk_pkg::KIND_SET_EVICT, f, $urandom_range(3) != 0);
            else if (r < 79) push_req(lruk_pkg::KIND_REMOVE, f, 1'($urandom_range(1)));
            else push_req(lruk_pkg::KIND_EVICT, lruk_pkg::FRAME_W'($urandom_range(255)),
                          1'($urandom_range(1)));
            i++;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || start || expected_rsp_q.size() != 0)
         @(posedge clock);
      // give the last transaction time to settle before the config changes
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lruk_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [lruk_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == lruk_pkg::CSR_K_VALUE) k_cfg = data[lruk_pkg::K_W-1:0];
      else limit_cfg = data[lruk_pkg::LIMIT_W-1:0];
   endtask

   task automatic run_phase(input logic [lruk_pkg::K_W-1:0] k,
                            input logic [lruk_pkg::LIMIT_W-1:0] lim,
                            input int n, input logic fill);
      logic [lruk_pkg::CSR_DATA_W-lruk_pkg::K_W-1:0] junk;
      wait_drained();
      // upper bits of the k write are not stored
      junk = (lruk_pkg::CSR_DATA_W-lruk_pkg::K_W)'($urandom_range(7));
      write_csr(lruk_pkg::CSR_K_VALUE, {junk, k});
      write_csr(lruk_pkg::CSR_FRAMES_IN_USE, lim);
      add_random(n, fill);
   endtask

   initial begin : stimulus
      for (int f = 0; f < lruk_pkg::FRAME_COUNT_DEF; f++) begin
         drop_frame(f);
         for (int j = 0; j < lruk_pkg::MAX_K_DEF; j++) stamps[f][j] = '0;
      end
      stamp_ctr = '0;
      evict_total = '0;
      k_cfg = lruk_pkg::K_RESET;
      limit_cfg = lruk_pkg::LIMIT_RESET;

      // directed part at the reset config, k 2 and all 64 frames
      push_req(lruk_pkg::KIND_EVICT, 8'd0, 1'b0);        // nothing to evict
      push_req(lruk_pkg::KIND_SET_EVICT, 8'd3, 1'b1);    // untracked
      push_req(lruk_pkg::KIND_REMOVE, 8'd3, 1'b0);       // untracked
      push_req(lruk_pkg::KIND_ACCESS, 8'd255, 1'b0);     // out of range
      push_req(lruk_pkg::KIND_ACCESS, 8'd64, 1'b0);
      push_req(lruk_pkg::KIND_ACCESS, 8'd0, 1'b0);
      push_req(lruk_pkg::KIND_ACCESS, 8'd63, 1'b1);
      push_req(lruk_pkg::KIND_ACCESS, 8'd0, 1'b0);
      push_req(lruk_pkg::KIND_REMOVE, 8'd0, 1'b0);       // not evictable yet
      push_req(lruk_pkg::KIND_SET_EVICT, 8'd0, 1'b1);
      push_req(lruk_pkg::KIND_SET_EVICT, 8'd0, 1'b1);    // no double count
      push_req(lruk_pkg::KIND_SET_EVICT, 8'd63, 1'b1);
      push_req(lruk_pkg::KIND_EVICT, 8'd0, 1'b0);        // 63 has infinite distance
      push_req(lruk_pkg::KIND_ACCESS, 8'd5, 1'b0);
      push_req(lruk_pkg::KIND_ACCESS, 8'd6, 1'b0);
      push_req(lruk_pkg::KIND_SET_EVICT, 8'd6, 1'b1);
      push_req(lruk_pkg::KIND_SET_EVICT, 8'd5, 1'b1);
      push_req(lruk_pkg::KIND_EVICT, 8'd0, 1'b0);        // earliest first access wins
      push_req(lruk_pkg::KIND_SET_EVICT, 8'd6, 1'b0);
      push_req(lruk_pkg::KIND_REMOVE, 8'd6, 1'b1);
      push_req(lruk_pkg::KIND_REMOVE, 8'd0, 1'b0);
      push_req(lruk_pkg::KIND_EVICT, 8'd0, 1'b0);
      push_req(lruk_pkg::KIND_SET_EVICT, 8'd128, 1'b1);
      push_req(lruk_pkg::KIND_EVICT, 8'd200, 1'b1);      // unused fields ignored
      add_random(100, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_phase(4'd1, 7'd64, 150, 1'b0);
      run_phase(4'd8, 7'd64, 160, 1'b0);
      run_phase(4'd3, 7'd16, 200, 1'b0);
      run_phase(4'd15, 7'd127, 150, 1'b0);
      run_phase(4'd0, 7'd5, 150, 1'b0);
      run_phase(4'd4, 7'd1, 100, 1'b0);
      run_phase(4'd8, 7'd2, 100, 1'b0);
      run_phase(4'd2, 7'd0, 40, 1'b0);
      run_phase(4'd5, 7'd64, 120, 1'b1);

      while (pending_q.size() != 0 || start || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && expected_rsp_q.size() == 0) begin
         $display("lru_k_frame_replacer test passed");
      end else begin
         $display("lru_k_frame_replacer test failed");
      end
      $finish;
   end

endmodule
